// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the RTL; each expects clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define CHK_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define CHK_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/parm_pkg.sv -----
// Shared types, constants and helper functions for the planar arm step block.
package parm_pkg;

	localparam int ANGLE_BITS = 16;
	localparam int TRIG_W     = 16;
	localparam int POS_W      = 15;
	localparam int IN_DATA_W  = 16;
	localparam int IN_USED_W  = 10;
	localparam int OUT_DATA_W = 112;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// divider sizes
	localparam int NUM_W     = 27;
	localparam int DEN_W     = 24;
	localparam int REM_W     = 58;
	localparam int DD_W      = DEN_W + 32;
	localparam int DIV_STEPS = 17;
	localparam int QUO_W     = 15;

	localparam logic [ANGLE_BITS-1:0] QUARTER_TURN = ANGLE_BITS'(1) << (ANGLE_BITS - 2);
	localparam logic [ANGLE_BITS-1:0] RST_FIRST    = ANGLE_BITS'(7) << (ANGLE_BITS - 3);
	localparam logic [ANGLE_BITS-1:0] RST_SECOND   = ANGLE_BITS'(1) << (ANGLE_BITS - 3);
	localparam logic [ANGLE_BITS-1:0] RST_TOOL     = '0;

	localparam logic [14:0] Q14_ONE = 15'd16384;
	localparam logic [14:0] SIN_K1  = 15'd25736;
	localparam logic [14:0] SIN_K3  = 15'd10512;
	localparam logic [14:0] SIN_K5  = 15'd1160;

	// 1/(2*pi) scaled by 2^32, split into two 15 bit halves
	localparam logic [29:0] INV_TWO_PI = 30'd683565276;
	localparam logic [14:0] K_LO = INV_TWO_PI[14:0];
	localparam logic [14:0] K_HI = INV_TWO_PI[29:15];

	localparam logic [15:0]       RST_JOINT_STEP = 16'd364;
	localparam logic [9:0]        RST_CART_SPEED = 10'd100;
	localparam logic [9:0]        RST_LINK_LEN   = 10'd250;
	localparam logic signed [14:0] RST_BASE_X    = 15'sd400;
	localparam logic signed [14:0] RST_BASE_Y    = 15'sd6400;
	localparam logic [15:0]       RST_MARGIN     = 16'd0;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_JOINT_STEP  = 3'd0,
		REG_CART_SPEED  = 3'd1,
		REG_LINK_LENGTH = 3'd2,
		REG_BASE_X      = 3'd3,
		REG_BASE_Y      = 3'd4,
		REG_SING_MARGIN = 3'd5
	} cfg_reg_t;

	typedef enum logic [2:0] {
		TRIG_S21,
		TRIG_C1,
		TRIG_S1,
		TRIG_C2,
		TRIG_S2
	} trig_sel_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_TRIG,
		ST_TRIG_WAIT,
		ST_DET1,
		ST_DET2,
		ST_DET3,
		ST_SUM,
		ST_NUM,
		ST_DIV,
		ST_DIV_WAIT,
		ST_UPDATE,
		ST_POS1,
		ST_POS2,
		ST_OUT
	} ctrl_state_t;

	typedef struct packed {
		logic      load;
		logic      trig_start;
		trig_sel_t trig_sel;
		logic      det_mul1;
		logic      det_mul2;
		logic      det_check;
		logic      sum;
		logic      num;
		logic      div_start;
		logic      div_sel;
		logic      update;
		logic      pos_mul;
		logic      pos_round;
		logic      out_load;
	} parm_cmd_t;

	typedef struct packed {
		logic move;
		logic trig_busy;
		logic trig_done;
		logic det_small;
		logic div_done;
		logic out_free;
	} parm_sts_t;

	// 01 -> +1, 11 -> -1, anything else -> 0
	function automatic logic signed [1:0] dir_of(input logic [1:0] v);
		logic signed [1:0] d;
		unique case (v)
			2'b01:   d = 2'sd1;
			2'b11:   d = -2'sd1;
			default: d = 2'sd0;
		endcase
		return d;
	endfunction

	function automatic logic [POS_W-1:0] sat_pos(input logic signed [17:0] v);
		logic [POS_W-1:0] r;
		priority if (v > 18'sd16383)
			r = 15'h3FFF;
		else if (v < -18'sd16384)
			r = 15'h4000;
		else
			r = v[POS_W-1:0];
		return r;
	endfunction

endpackage

// ----- rtl/core/parm_trig.sv -----
// Iterative Q14 sine unit: fifth-order quarter-wave polynomial, one multiply per cycle.
module parm_trig import parm_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [ANGLE_BITS-1:0]        angle,
	output logic                         busy,
	output logic                         done,
	output logic signed [TRIG_W-1:0]     result
);

	logic [1:0]               cnt_q;
	logic                     busy_q, done_q, neg_q;
	logic [14:0]              x_q, x2_q, t_q;
	logic signed [TRIG_W-1:0] result_q;

	logic [1:0]  quad;
	logic [14:0] x_raw, x_in, op_a, op_b, sh;
	logic [29:0] prod;

	assign quad  = angle[ANGLE_BITS-1 -: 2];
	assign x_raw = {1'b0, angle[ANGLE_BITS-3 -: 14]};
	assign x_in  = quad[0] ? 15'(Q14_ONE - x_raw) : x_raw;

	always_comb begin
		unique case (cnt_q)
			2'd0: begin op_a = x_q;    op_b = x_q;  end
			2'd1: begin op_a = SIN_K5; op_b = x2_q; end
			2'd2: begin op_a = x2_q;   op_b = t_q;  end
			default: begin op_a = x_q; op_b = t_q;  end
		endcase
	end

	assign prod = op_a * op_b;
	assign sh   = prod[28:14];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == 2'd3) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= x_in;
			neg_q <= quad[1];
		end else if (busy_q) begin
			unique case (cnt_q)
				2'd0: x2_q <= sh;
				2'd1: t_q  <= 15'(SIN_K3 - sh);
				2'd2: t_q  <= 15'(SIN_K1 - sh);
				default: result_q <= neg_q ? -$signed({1'b0, sh}) : $signed({1'b0, sh});
			endcase
		end
	end

	assign busy   = busy_q;
	assign done   = done_q;
	assign result = result_q;

endmodule

// ----- rtl/core/parm_div.sv -----
// Rate divider: scales the numerator by 1/(2*pi), then restoring division with rounding.
module parm_div import parm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [QUO_W-1:0] quo
);

	localparam logic [4:0] LAST = 5'(2 + DIV_STEPS);

	logic [4:0]           cnt_q;
	logic                 busy_q, done_q;
	logic [NUM_W-1:0]     num_q;
	logic [DEN_W-1:0]     d_q;
	logic [NUM_W+14:0]    plo_q, phi_q, prod;
	logic [REM_W-1:0]     rem_q, dd_ext;
	logic [DD_W-1:0]      dd_q;
	logic [DIV_STEPS-1:0] q_q;
	logic                 ge;

	assign prod   = num_q * ((cnt_q == 5'd0) ? K_LO : K_HI);
	assign dd_ext = REM_W'(dd_q);
	assign ge     = rem_q >= dd_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			d_q   <= den;
		end else if (busy_q) begin
			priority if (cnt_q == 5'd0)
				plo_q <= prod;
			else if (cnt_q == 5'd1)
				phi_q <= prod;
			else if (cnt_q == 5'd2) begin
				// numerator plus half the divisor for round-to-nearest
				rem_q <= (REM_W'(phi_q) << 15) + REM_W'(plo_q) + (REM_W'(d_q) << 15);
				// divisor starts at den * 2^32; first quotient bit is worth 2^16
				dd_q  <= {d_q, 32'b0};
				q_q   <= '0;
			end else begin
				if (ge)
					rem_q <= rem_q - dd_ext;
				dd_q <= dd_q >> 1;
				q_q  <= {q_q[DIV_STEPS-2:0], ge};
			end
		end
	end

	// top quotient bit means far beyond a quarter turn
	assign quo  = (q_q[DIV_STEPS-1] || (q_q[DIV_STEPS-2:0] > 16'd16384)) ?
		Q14_ONE : q_q[QUO_W-1:0];
	assign done = done_q;

endmodule

// ----- rtl/core/parm_dp.sv -----
// Datapath: config and angle registers, trig and divider units, position and output stage.
module parm_dp import parm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  parm_cmd_t             cmd,
	output parm_sts_t             sts,
	input  logic [IN_USED_W-1:0]  in_data,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic [OUT_DATA_W-1:0] out_data,
	output logic                  out_valid,
	input  logic                  out_ready
);

	logic [15:0]        joint_step_q, margin_q;
	logic [9:0]         cart_speed_q, link_len_q;
	logic signed [14:0] base_x_q, base_y_q;

	logic [ANGLE_BITS-1:0] a1_q, a2_q, a3_q;
	logic signed [1:0]     mx_q, my_q;
	logic                  sing_q;

	logic signed [TRIG_W-1:0] s21_q, c1_q, s1_q, c2_q, s2_q;
	logic [DEN_W-1:0]         dmag_q;
	logic [33:0]              detm_q;
	logic [16:0]              sum1_mag_q, sum2_mag_q;
	logic                     sum1_neg_q, sum2_neg_q;
	logic [NUM_W-1:0]         n1_q, n2_q;
	logic signed [15:0]       r1_q, r2_q;
	logic signed [26:0]       lp_q [4];
	logic signed [15:0]       term_q [4];
	logic [OUT_DATA_W-1:0]    out_q;
	logic                     out_valid_q;

	logic                     trig_busy, trig_done, div_done;
	logic signed [TRIG_W-1:0] trig_res;
	logic [ANGLE_BITS-1:0]    trig_angle;
	logic [QUO_W-1:0]         quo;

	function automatic logic [15:0] jog(input logic signed [2:0] k, input logic [15:0] s);
		logic signed [16:0] p;
		p = 17'(k) * $signed({1'b0, s});
		return p[15:0];
	endfunction

	function automatic logic signed [18:0] pick(input logic signed [1:0] d,
			input logic signed [18:0] v);
		logic signed [18:0] r;
		priority if (d == 2'sd1)
			r = v;
		else if (d == -2'sd1)
			r = -v;
		else
			r = '0;
		return r;
	endfunction

	// shift right by 10, rounding half away from zero
	function automatic logic signed [15:0] round10(input logic signed [26:0] p);
		logic [26:0] m;
		logic [16:0] r;
		m = p[26] ? 27'(-p) : 27'(p);
		r = 17'((m + 27'd512) >> 10);
		return p[26] ? -$signed({1'b0, r[14:0]}) : $signed({1'b0, r[14:0]});
	endfunction

	// --- input decode and jog amounts
	logic signed [1:0] jb, je, jt;
	logic signed [2:0] k1, k2, k3;
	assign jb = dir_of(in_data[5:4]);
	assign je = dir_of(in_data[7:6]);
	assign jt = dir_of(in_data[9:8]);
	assign k1 = 3'(jb);
	assign k2 = k1 + 3'(je);
	assign k3 = k2 + 3'(jt);

	// --- trig unit
	always_comb begin
		unique case (cmd.trig_sel)
			TRIG_S21: trig_angle = a2_q - a1_q;
			TRIG_C1:  trig_angle = a1_q + QUARTER_TURN;
			TRIG_S1:  trig_angle = a1_q;
			TRIG_C2:  trig_angle = a2_q + QUARTER_TURN;
			TRIG_S2:  trig_angle = a2_q;
			default:  trig_angle = a1_q;
		endcase
	end

	parm_trig u_trig (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.trig_start),
		.angle  (trig_angle),
		.busy   (trig_busy),
		.done   (trig_done),
		.result (trig_res)
	);

	// --- determinant
	logic [14:0] s21_abs;
	logic [24:0] dprod;
	logic [33:0] margin_ext;
	assign s21_abs    = s21_q[TRIG_W-1] ? 15'(-s21_q) : 15'(s21_q);
	assign dprod      = s21_abs * link_len_q;
	assign margin_ext = {4'b0, margin_q, 14'b0};

	// --- numerators
	logic signed [18:0] sum1, sum2;
	assign sum1 = pick(mx_q, 19'(c2_q)) + pick(my_q, 19'(s2_q));
	assign sum2 = -(pick(mx_q, 19'(c1_q) + 19'(c2_q)) + pick(my_q, 19'(s1_q) + 19'(s2_q)));

	// --- divider
	logic              q_neg;
	logic signed [15:0] r_new;
	assign q_neg = (cmd.div_sel ? sum2_neg_q : sum1_neg_q) ^ s21_q[TRIG_W-1];
	assign r_new = q_neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});

	parm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (cmd.div_sel ? n2_q : n1_q),
		.den    (dmag_q),
		.done   (div_done),
		.quo    (quo)
	);

	// --- positions
	logic signed [16:0] ex, ey;
	logic signed [17:0] wx, wy;
	assign ex = 17'(base_x_q) + 17'(term_q[0]);
	assign ey = 17'(base_y_q) + 17'(term_q[1]);
	assign wx = 18'(ex) + 18'(term_q[2]);
	assign wy = 18'(ey) + 18'(term_q[3]);

	// --- config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			joint_step_q <= RST_JOINT_STEP;
			cart_speed_q <= RST_CART_SPEED;
			link_len_q   <= RST_LINK_LEN;
			base_x_q     <= RST_BASE_X;
			base_y_q     <= RST_BASE_Y;
			margin_q     <= RST_MARGIN;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_JOINT_STEP:  joint_step_q <= cfg_data;
				REG_CART_SPEED:  cart_speed_q <= cfg_data[9:0];
				REG_LINK_LENGTH: link_len_q   <= cfg_data[9:0];
				REG_BASE_X:      base_x_q     <= $signed(cfg_data[14:0]);
				REG_BASE_Y:      base_y_q     <= $signed(cfg_data[14:0]);
				REG_SING_MARGIN: margin_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// --- arm state and control flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a1_q        <= RST_FIRST;
			a2_q        <= RST_SECOND;
			a3_q        <= RST_TOOL;
			mx_q        <= '0;
			my_q        <= '0;
			sing_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				a1_q   <= a1_q + jog(k1, joint_step_q);
				a2_q   <= a2_q + jog(k2, joint_step_q);
				a3_q   <= a3_q + jog(k3, joint_step_q);
				mx_q   <= dir_of(in_data[1:0]);
				my_q   <= dir_of(in_data[3:2]);
				sing_q <= 1'b0;
			end else if (cmd.update) begin
				a1_q <= a1_q + 16'(r1_q);
				a2_q <= a2_q + 16'(r1_q) + 16'(r2_q);
			end
			if (cmd.det_check && (detm_q <= margin_ext))
				sing_q <= 1'b1;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// --- working registers
	always_ff @(posedge clk) begin
		if (trig_done) begin
			unique case (cmd.trig_sel)
				TRIG_S21: s21_q <= trig_res;
				TRIG_C1:  c1_q  <= trig_res;
				TRIG_S1:  s1_q  <= trig_res;
				TRIG_C2:  c2_q  <= trig_res;
				TRIG_S2:  s2_q  <= trig_res;
				default: ;
			endcase
		end
		if (cmd.det_mul1)
			dmag_q <= dprod[DEN_W-1:0];
		if (cmd.det_mul2)
			detm_q <= dmag_q * link_len_q;
		if (cmd.sum) begin
			sum1_neg_q <= sum1[18];
			sum2_neg_q <= sum2[18];
			sum1_mag_q <= sum1[18] ? 17'(-sum1) : 17'(sum1);
			sum2_mag_q <= sum2[18] ? 17'(-sum2) : 17'(sum2);
		end
		if (cmd.num) begin
			n1_q <= sum1_mag_q * cart_speed_q;
			n2_q <= sum2_mag_q * cart_speed_q;
		end
		if (div_done) begin
			if (cmd.div_sel)
				r2_q <= r_new;
			else
				r1_q <= r_new;
		end
		if (cmd.pos_mul) begin
			lp_q[0] <= $signed({1'b0, link_len_q}) * c1_q;
			lp_q[1] <= $signed({1'b0, link_len_q}) * s1_q;
			lp_q[2] <= $signed({1'b0, link_len_q}) * c2_q;
			lp_q[3] <= $signed({1'b0, link_len_q}) * s2_q;
		end
		if (cmd.pos_round) begin
			for (int i = 0; i < 4; i++)
				term_q[i] <= round10(lp_q[i]);
		end
		if (cmd.out_load)
			out_q <= {3'b0, sing_q, sat_pos(wy), sat_pos(wx),
				sat_pos(18'(ey)), sat_pos(18'(ex)), a3_q, a2_q, a1_q};
	end

	assign sts.move      = (mx_q != 2'sd0) || (my_q != 2'sd0);
	assign sts.trig_busy = trig_busy;
	assign sts.trig_done = trig_done;
	assign sts.det_small = detm_q <= margin_ext;
	assign sts.div_done  = div_done;
	assign sts.out_free  = !out_valid_q || out_ready;

	assign out_data  = out_q;
	assign out_valid = out_valid_q;

endmodule

// ----- rtl/core/parm_ctrl.sv -----
// Controller FSM: sequences jog, determinant test, inverse kinematics and position output.
module parm_ctrl import parm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  parm_sts_t sts,
	output parm_cmd_t cmd
);

	ctrl_state_t state_q, state_d;
	trig_sel_t   sel_q, sel_d;
	logic        ik_q, ik_d;
	logic        dsel_q, dsel_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sel_q   <= TRIG_C1;
			ik_q    <= 1'b0;
			dsel_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			sel_q   <= sel_d;
			ik_q    <= ik_d;
			dsel_q  <= dsel_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		sel_d   = sel_q;
		ik_d    = ik_q;
		dsel_d  = dsel_q;
		unique case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_DECIDE;
			ST_DECIDE: begin
				sel_d   = sts.move ? TRIG_S21 : TRIG_C1;
				ik_d    = sts.move;
				state_d = ST_TRIG;
			end
			ST_TRIG: state_d = ST_TRIG_WAIT;
			ST_TRIG_WAIT: begin
				if (sts.trig_done) begin
					priority if (sel_q == TRIG_S21)
						state_d = ST_DET1;
					else if (sel_q == TRIG_S2)
						state_d = ik_q ? ST_SUM : ST_POS1;
					else begin
						sel_d   = trig_sel_t'(sel_q + 3'd1);
						state_d = ST_TRIG;
					end
				end
			end
			ST_DET1: state_d = ST_DET2;
			ST_DET2: state_d = ST_DET3;
			ST_DET3: begin
				sel_d = TRIG_C1;
				if (sts.det_small)
					ik_d = 1'b0;
				state_d = ST_TRIG;
			end
			ST_SUM: state_d = ST_NUM;
			ST_NUM: begin
				dsel_d  = 1'b0;
				state_d = ST_DIV;
			end
			ST_DIV: state_d = ST_DIV_WAIT;
			ST_DIV_WAIT: begin
				if (sts.div_done) begin
					if (dsel_q)
						state_d = ST_UPDATE;
					else begin
						dsel_d  = 1'b1;
						state_d = ST_DIV;
					end
				end
			end
			ST_UPDATE: begin
				sel_d   = TRIG_C1;
				ik_d    = 1'b0;
				state_d = ST_TRIG;
			end
			ST_POS1: state_d = ST_POS2;
			ST_POS2: state_d = ST_OUT;
			ST_OUT: if (sts.out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd          = '0;
		cmd.trig_sel = sel_q;
		cmd.div_sel  = dsel_q;
		unique case (state_q)
			ST_IDLE:     cmd.load       = in_valid;
			ST_TRIG:     cmd.trig_start = 1'b1;
			ST_DET1:     cmd.det_mul1   = 1'b1;
			ST_DET2:     cmd.det_mul2   = 1'b1;
			ST_DET3:     cmd.det_check  = 1'b1;
			ST_SUM:      cmd.sum        = 1'b1;
			ST_NUM:      cmd.num        = 1'b1;
			ST_DIV:      cmd.div_start  = 1'b1;
			ST_UPDATE:   cmd.update     = 1'b1;
			ST_POS1:     cmd.pos_mul    = 1'b1;
			ST_POS2:     cmd.pos_round  = 1'b1;
			ST_OUT:      cmd.out_load   = sts.out_free;
			default: ;
		endcase
	end

	assign in_ready = (state_q == ST_IDLE);

endmodule

// ----- rtl/core/planar_arm_jacobian_step.sv -----
// Top level of the planar arm step block: jog, Jacobian-inverse move and joint positions.
//
//  channel   dir  handshake                    contents
//  s_axis    in   s_axis_tvalid/s_axis_tready  direction codes, one control frame
//  m_axis    out  m_axis_tvalid/m_axis_tready  angles, elbow/wrist points, singular
//  cfg       in   cfg_wr_en                    register index and write data
//
// One transaction is worked at a time by an FSM and a sequenced datapath.
// The shared sine unit works out 4 values without a move, 5 for a singular move and
// 9 with IK motion, which also passes two rates through the bit-serial divider.
// Reset puts the arm at -45/+45 degrees with the tool at 0 and loads config defaults.
// A result waits in the output register; the next frame is taken meanwhile
// and only stalls at its own output if the previous result is still not taken.
`include "assert_macros.svh"

module planar_arm_jacobian_step import parm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// [1:0] move_x, [3:2] move_y, [5:4] turn_base, [7:6] turn_elbow, [9:8] turn_tool
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// [15:0] first_angle, [31:16] second_angle, [47:32] tool_angle,
	// [62:48] elbow_x, [77:63] elbow_y, [92:78] wrist_x, [107:93] wrist_y, [108] singular
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	parm_cmd_t cmd;
	parm_sts_t sts;

	// sequencing
	parm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// arithmetic, state and output register
	parm_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_data   (s_axis_tdata[IN_USED_W-1:0]),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_data  (m_axis_tdata),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready)
	);

	// a frame is worked alone: no second transaction right behind the first
	`CHK_NEXT(a_one_frame, s_axis_tvalid && s_axis_tready, !s_axis_tready, "frame overlap")
	// the output register is loaded only when its slot is free
	`CHK_IMPLIES(a_out_slot, cmd.out_load, !m_axis_tvalid || m_axis_tready, "result overwritten")
	// the sine unit is never restarted mid-evaluation
	`CHK_IMPLIES(a_trig_idle, cmd.trig_start, !sts.trig_busy, "sine unit restarted while busy")

endmodule
